>>> rtl/aot_pkg.sv
// ----------------------------------------------------------------------------
// aot_pkg
// shared types and constants of the aging obstacle table
// ----------------------------------------------------------------------------
package aot_pkg;

    localparam int SLOTS_DEF  = 4;
    localparam int POS_W      = 16;
    localparam int LIFE_W     = 8;
    localparam int DIST_W     = 12;
    localparam int SQ_W       = 2 * POS_W;
    localparam int LIM_W      = 2 * DIST_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int OUT_SLOT_W = 4;
    localparam int OUT_CNT_W  = 5;

    localparam logic [LIFE_W-1:0] FULL_LIFE_RST = 8'd100;
    localparam logic [DIST_W-1:0] MERGE_RST     = 12'd150;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_ADD  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_AGED          = 2'd0,
        ACT_MATCH_KEEP    = 2'd1,
        ACT_MATCH_REFRESH = 2'd2,
        ACT_PLACED        = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_LIFE  = 2'd0,
        REG_MERGE_DIST = 2'd1
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIM,
        S_SQX,
        S_SQY,
        S_PLACE,
        S_AGE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd                    cmd;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_in_req;

    typedef struct packed {
        t_action                 action;
        logic [OUT_SLOT_W-1:0]   slot;
        logic [OUT_CNT_W-1:0]    live_count;
    } t_out_req;

endpackage

>>> rtl/aging_obstacle_table.sv
// ----------------------------------------------------------------------------
// aging_obstacle_table
// small obstacle table with life counters, merge on detection, aging on tick
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall / i_in_data): one request is a tick
//   (ages every live entry) or an add (detection at pos_x, pos_y)
//   output channel (o_out_valid / i_out_stall / o_out_data): one result per
//   request with action, slot and the live entry count after the request
//   config channel (i_cfg_valid / o_cfg_ready): full_life at index 0,
//   merge_distance at index 1, other indexes ignored; always ready
// operation
//   one request at a time; a single squaring multiplier does all the work
//   add: merge distance squared first, then per live slot scanned dx squared,
//   then dy squared with sum and compare; a dead slot gets no distance test,
//   a place step follows when nothing matches, then the hand-off
//   tick: one slot per cycle, then the hand-off
//   the next request is taken the cycle after the result is handed off
// reset
//   all lives cleared, registers back to 100 and 150, positions left as is
// receiver stall
//   the result waits in the output register; a new request can be taken
//   meanwhile, and its result waits until the output register frees up
// ----------------------------------------------------------------------------
module aging_obstacle_table #(
    parameter int SLOTS = aot_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  aot_pkg::t_in_req                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output aot_pkg::t_out_req               o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [aot_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aot_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // configuration
    logic [aot_pkg::LIFE_W-1:0] r_full_life;
    logic [aot_pkg::DIST_W-1:0] r_merge;

    // table: positions have no reset, lives do
    logic signed [aot_pkg::POS_W-1:0]  r_x    [SLOTS];
    logic signed [aot_pkg::POS_W-1:0]  r_y    [SLOTS];
    logic        [aot_pkg::LIFE_W-1:0] r_life [SLOTS];

    // sequencer state and working registers
    aot_pkg::t_state                  r_state, n_state;
    logic signed [aot_pkg::POS_W-1:0] r_px, n_px;
    logic signed [aot_pkg::POS_W-1:0] r_py, n_py;
    logic [aot_pkg::LIM_W-1:0]        r_lim, n_lim;
    logic [aot_pkg::SQ_W-1:0]         r_sq, n_sq;
    logic [SLOT_W-1:0]                r_idx, n_idx;
    logic [SLOT_W-1:0]                r_oldest, n_oldest;
    logic [aot_pkg::LIFE_W-1:0]       r_oldest_life, n_oldest_life;
    aot_pkg::t_action                 r_action, n_action;
    logic [SLOT_W-1:0]                r_slot, n_slot;
    logic [CNT_W-1:0]                 r_live, n_live;
    logic                             r_out_valid, n_out_valid;
    aot_pkg::t_out_req                r_out, n_out;

    // table write controls, all at r_idx
    logic wr_en;
    logic age_en;

    // shared unit
    logic signed [aot_pkg::POS_W:0] sq_a, sq_b;
    logic [aot_pkg::SQ_W-1:0]       sq;
    logic [aot_pkg::SQ_W:0]         dist_sum;
    logic [aot_pkg::LIFE_W-1:0]     cur_life;
    logic                           skip;
    logic                           cfg_wr;

    assign cur_life    = r_life[r_idx];
    assign o_in_stall  = (r_state != aot_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    // operand select for the squaring unit
    always_comb begin
        unique case (r_state)
            aot_pkg::S_LIM: begin
                sq_a = (aot_pkg::POS_W + 1)'(r_merge);
                sq_b = '0;
            end
            aot_pkg::S_SQX: begin
                sq_a = {r_px[aot_pkg::POS_W-1], r_px};
                sq_b = {r_x[r_idx][aot_pkg::POS_W-1], r_x[r_idx]};
            end
            default: begin
                sq_a = {r_py[aot_pkg::POS_W-1], r_py};
                sq_b = {r_y[r_idx][aot_pkg::POS_W-1], r_y[r_idx]};
            end
        endcase
    end

    aot_sqr_unit u_sqr (
        .i_a  (sq_a),
        .i_b  (sq_b),
        .o_sq (sq)
    );

    // dx squared from the previous cycle plus dy squared now
    assign dist_sum = {1'b0, r_sq} + {1'b0, sq};

    // sequencer: next state and datapath controls
    always_comb begin
        n_state       = r_state;
        n_px          = r_px;
        n_py          = r_py;
        n_lim         = r_lim;
        n_sq          = r_sq;
        n_idx         = r_idx;
        n_oldest      = r_oldest;
        n_oldest_life = r_oldest_life;
        n_action      = r_action;
        n_slot        = r_slot;
        n_live        = r_live;
        n_out_valid   = r_out_valid & i_out_stall;
        n_out         = r_out;
        wr_en         = 1'b0;
        age_en        = 1'b0;
        skip          = 1'b0;

        unique case (r_state)
            aot_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_px  = i_in_data.pos_x;
                    n_py  = i_in_data.pos_y;
                    n_idx = '0;
                    if (i_in_data.cmd == aot_pkg::CMD_ADD) begin
                        n_state = aot_pkg::S_LIM;
                    end else begin
                        n_state = aot_pkg::S_AGE;
                    end
                end
            end
            aot_pkg::S_LIM: begin
                n_lim         = sq[aot_pkg::LIM_W-1:0];
                n_idx         = '0;
                n_oldest      = '0;
                n_oldest_life = r_full_life;
                n_state       = aot_pkg::S_SQX;
            end
            aot_pkg::S_SQX: begin
                if (cur_life == '0) begin
                    // dead slot: no distance test
                    skip = 1'b1;
                end else begin
                    n_sq    = sq;
                    n_state = aot_pkg::S_SQY;
                end
            end
            aot_pkg::S_SQY: begin
                if (dist_sum < (aot_pkg::SQ_W + 1)'(r_lim)) begin
                    n_slot  = r_idx;
                    n_state = aot_pkg::S_DONE;
                    if (cur_life < r_full_life) begin
                        wr_en    = 1'b1;
                        n_action = aot_pkg::ACT_MATCH_REFRESH;
                    end else begin
                        n_action = aot_pkg::ACT_MATCH_KEEP;
                    end
                end else begin
                    skip = 1'b1;
                end
            end
            aot_pkg::S_PLACE: begin
                // r_idx points at the oldest slot here
                wr_en    = 1'b1;
                n_slot   = r_idx;
                n_action = aot_pkg::ACT_PLACED;
                n_live   = CNT_W'(r_live - CNT_W'(cur_life != '0)
                                         + CNT_W'(r_full_life != '0));
                n_state  = aot_pkg::S_DONE;
            end
            aot_pkg::S_AGE: begin
                age_en = 1'b1;
                if (cur_life == aot_pkg::LIFE_W'(1)) begin
                    n_live = CNT_W'(r_live - CNT_W'(1));
                end
                if (r_idx == LAST_SLOT) begin
                    n_action = aot_pkg::ACT_AGED;
                    n_slot   = '0;
                    n_state  = aot_pkg::S_DONE;
                end else begin
                    n_idx = SLOT_W'(r_idx + SLOT_W'(1));
                end
            end
            aot_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.action     = r_action;
                    n_out.slot       = aot_pkg::OUT_SLOT_W'(r_slot);
                    n_out.live_count = aot_pkg::OUT_CNT_W'(r_live);
                    n_out_valid      = 1'b1;
                    n_state          = aot_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = aot_pkg::S_IDLE;
            end
        endcase

        // no match at this slot: track the oldest and move on
        if (skip) begin
            if (cur_life < r_oldest_life) begin
                n_oldest      = r_idx;
                n_oldest_life = cur_life;
            end
            if (r_idx == LAST_SLOT) begin
                n_idx   = (cur_life < r_oldest_life) ? r_idx : r_oldest;
                n_state = aot_pkg::S_PLACE;
            end else begin
                n_idx   = SLOT_W'(r_idx + SLOT_W'(1));
                n_state = aot_pkg::S_SQX;
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aot_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_full_life <= aot_pkg::FULL_LIFE_RST;
            r_merge     <= aot_pkg::MERGE_RST;
        end else begin
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    aot_pkg::REG_FULL_LIFE:  r_full_life <= i_cfg_data[aot_pkg::LIFE_W-1:0];
                    aot_pkg::REG_MERGE_DIST: r_merge     <= i_cfg_data[aot_pkg::DIST_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_px          <= n_px;
        r_py          <= n_py;
        r_lim         <= n_lim;
        r_sq          <= n_sq;
        r_idx         <= n_idx;
        r_oldest      <= n_oldest;
        r_oldest_life <= n_oldest_life;
        r_action      <= n_action;
        r_slot        <= n_slot;
        r_out         <= n_out;
    end

    // life counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_life[i] <= '0;
            end
        end else if (wr_en) begin
            r_life[r_idx] <= r_full_life;
        end else if (age_en && (cur_life != '0)) begin
            r_life[r_idx] <= cur_life - aot_pkg::LIFE_W'(1);
        end
    end

    // positions
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_x[r_idx] <= r_px;
            r_y[r_idx] <= r_py;
        end
    end

endmodule

>>> rtl/aot_sqr_unit.sv
// ----------------------------------------------------------------------------
// aot_sqr_unit
// shared squaring unit: (a - b) squared, one result per cycle
// ----------------------------------------------------------------------------
module aot_sqr_unit (
    input  logic signed [aot_pkg::POS_W:0]  i_a,
    input  logic signed [aot_pkg::POS_W:0]  i_b,
    output logic [aot_pkg::SQ_W-1:0]        o_sq
);

    logic signed [aot_pkg::POS_W:0] diff;
    logic        [aot_pkg::POS_W:0] mag;
    logic        [aot_pkg::POS_W-1:0] mag_lo;

    // operands come from 16-bit values, so the magnitude fits 16 bits
    assign diff   = i_a - i_b;
    assign mag    = diff[aot_pkg::POS_W] ? -diff : diff;
    assign mag_lo = mag[aot_pkg::POS_W-1:0];
    assign o_sq   = aot_pkg::SQ_W'(mag_lo) * aot_pkg::SQ_W'(mag_lo);

endmodule

>>> rtl/aot_checker.sv
// ----------------------------------------------------------------------------
// aot_checker
// port-level checks of the aging obstacle table
// ----------------------------------------------------------------------------
module aot_checker #(
    parameter int SLOTS = aot_pkg::SLOTS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input aot_pkg::t_out_req               o_out_data
);

    // one request at a time: busy right after taking one
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while previous one in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // live count never exceeds the table size
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.live_count <= aot_pkg::OUT_CNT_W'(SLOTS)))
        else $error("live count out of range");

    // slot within table, and zero for a tick
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.slot < aot_pkg::OUT_SLOT_W'(SLOTS - 1) ||
                         o_out_data.slot == aot_pkg::OUT_SLOT_W'(SLOTS - 1)))
        else $error("slot out of range");

    a_tick_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.action == aot_pkg::ACT_AGED) |->
            (o_out_data.slot == '0))
        else $error("tick result with nonzero slot");

endmodule

bind aging_obstacle_table aot_checker #(.SLOTS(SLOTS)) u_aot_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the aging obstacle table against a cycle-free table predictor: a
// request driver and a result monitor run as clocked processes, every result
// is compared field by field with the predicted one, over directed corner
// requests and clustered random detections under several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int          SLOTS       = aot_pkg::SLOTS_DEF;
    localparam int          CLK_PERIOD  = 20;
    localparam int          RST_CYCLES  = 8;
    localparam int          CYCLE_LIMIT = 800000;
    localparam int          HOLD_LEN    = 300;
    localparam int          END_SLACK   = 2 * SLOTS + 8;
    localparam int          N_HOT       = 6;
    // indexes past the register list, writes there must be ignored
    localparam logic [aot_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [aot_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    aot_pkg::t_in_req                 i_in_data   = '0;
    logic                             i_out_stall = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic [aot_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [aot_pkg::CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    aot_pkg::t_out_req                o_out_data;
    logic                             o_cfg_ready;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    aging_obstacle_table #(
        .SLOTS(SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // predicted table: its own copy of registers, positions and lives
    // ------------------------------------------------------------------------
    logic [aot_pkg::LIFE_W-1:0]        cfg_full_life = aot_pkg::FULL_LIFE_RST;
    logic [aot_pkg::DIST_W-1:0]        cfg_merge     = aot_pkg::MERGE_RST;
    logic signed [aot_pkg::POS_W-1:0]  tbl_x    [SLOTS];
    logic signed [aot_pkg::POS_W-1:0]  tbl_y    [SLOTS];
    logic [aot_pkg::LIFE_W-1:0]        tbl_life [SLOTS];

    aot_pkg::t_in_req   obstacle_reqs_q[$];   // requests waiting for the driver
    aot_pkg::t_out_req  table_outcomes_q[$];  // predicted results, oldest first

    // stimulus knobs, set by the sequence while the block is idle
    logic      send_gaps_on   = 1'b1;
    logic      recv_stalls_on = 1'b1;
    logic      hold_go        = 1'b0;

    int        mismatch_cnt = 0;
    int        n_ticks      = 0;
    int        n_adds       = 0;
    int        n_settings   = 0;
    int        act_seen [4] = '{0, 0, 0, 0};

    // one table step: age on tick, merge or place on add
    function automatic aot_pkg::t_out_req table_step(input aot_pkg::t_in_req req);
        aot_pkg::t_out_req          res;
        longint                     dx;
        longint                     dy;
        longint                     lim;
        int                         oldest;
        logic [aot_pkg::LIFE_W-1:0] oldest_life;
        logic                       matched;
        int                         live;

        res.action = aot_pkg::ACT_AGED;
        res.slot   = '0;
        if (req.cmd == aot_pkg::CMD_TICK) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (tbl_life[s] != 0) begin
                    tbl_life[s] = tbl_life[s] - 1'b1;
                end
            end
        end else begin
            lim         = longint'(cfg_merge) * longint'(cfg_merge);
            oldest      = 0;
            oldest_life = cfg_full_life;
            matched     = 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                if (!matched) begin
                    dx = longint'($signed(req.pos_x)) - longint'(tbl_x[s]);
                    dy = longint'($signed(req.pos_y)) - longint'(tbl_y[s]);
                    if (tbl_life[s] != 0 && dx * dx + dy * dy < lim) begin
                        // first live entry inside the merge radius wins
                        matched  = 1'b1;
                        res.slot = aot_pkg::OUT_SLOT_W'(s);
                        if (tbl_life[s] < cfg_full_life) begin
                            tbl_x[s]    = req.pos_x;
                            tbl_y[s]    = req.pos_y;
                            tbl_life[s] = cfg_full_life;
                            res.action  = aot_pkg::ACT_MATCH_REFRESH;
                        end else begin
                            res.action  = aot_pkg::ACT_MATCH_KEEP;
                        end
                    end else if (tbl_life[s] < oldest_life) begin
                        oldest      = s;
                        oldest_life = tbl_life[s];
                    end
                end
            end
            if (!matched) begin
                // lowest life strictly below full, slot 0 when none is
                tbl_x[oldest]    = req.pos_x;
                tbl_y[oldest]    = req.pos_y;
                tbl_life[oldest] = cfg_full_life;
                res.slot         = aot_pkg::OUT_SLOT_W'(oldest);
                res.action       = aot_pkg::ACT_PLACED;
            end
        end
        live = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if (tbl_life[s] != 0) begin
                live++;
            end
        end
        res.live_count = aot_pkg::OUT_CNT_W'(live);
        return res;
    endfunction

    // mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // request driver: predicts at acceptance, then offers the next request
    // ------------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
            for (int s = 0; s < SLOTS; s++) begin
                tbl_life[s] = '0;
            end
        end else begin
            if (i_in_valid && !o_in_stall) begin
                table_outcomes_q.push_back(table_step(i_in_data));
                if (i_in_data.cmd == aot_pkg::CMD_TICK) begin
                    n_ticks++;
                end else begin
                    n_adds++;
                end
            end
            // a pending request holds still until it is taken
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    i_in_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end else if (obstacle_reqs_q.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= obstacle_reqs_q.pop_front();
                    send_gap   <= send_gaps_on ? pick_gap() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // long receiver hold-off, counted here, so the block backs up into its
    // input while the driver keeps offering
    // ------------------------------------------------------------------------
    int   hold_cycles = 0;
    logic hold_active = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_active <= 1'b0;
        end else if (hold_go && hold_cycles < HOLD_LEN) begin
            hold_cycles <= hold_cycles + 1;
            hold_active <= 1'b1;
        end else begin
            hold_active <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: compares each taken result with the oldest prediction
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin : result_monitor
        aot_pkg::t_out_req want;
        int                next_left;

        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (table_outcomes_q.size() == 0) begin
                    $error("result with no request pending: action %0d slot %0d live %0d",
                           o_out_data.action, o_out_data.slot, o_out_data.live_count);
                    mismatch_cnt++;
                end else begin
                    want = table_outcomes_q.pop_front();
                    act_seen[want.action]++;
                    if (o_out_data.action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action,
                               o_out_data.action);
                        mismatch_cnt++;
                    end
                    if (o_out_data.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, o_out_data.slot);
                        mismatch_cnt++;
                    end
                    if (o_out_data.live_count !== want.live_count) begin
                        $error("live_count: expected %0d, got %0d", want.live_count,
                               o_out_data.live_count);
                        mismatch_cnt++;
                    end
                end
            end
            // random stall runs: mostly none, some short, a few long
            if (stall_left > 0) begin
                next_left = stall_left - 1;
            end else if (recv_stalls_on) begin
                next_left = pick_gap();
            end else begin
                next_left = 0;
            end
            stall_left  <= next_left;
            i_out_stall <= hold_active || (next_left > 0);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    int unsigned cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    logic signed [aot_pkg::POS_W-1:0] hot_x [N_HOT];
    logic signed [aot_pkg::POS_W-1:0] hot_y [N_HOT];

    function automatic logic signed [aot_pkg::POS_W-1:0] clamp_pos(input int v);
        if (v > 32767) begin
            return 16'sd32767;
        end else if (v < -32768) begin
            return -16'sd32768;
        end
        return aot_pkg::POS_W'(v);
    endfunction

    task automatic push_tick();
        aot_pkg::t_in_req req;
        req.cmd   = aot_pkg::CMD_TICK;
        req.pos_x = '0;
        req.pos_y = '0;
        obstacle_reqs_q.push_back(req);
    endtask

    task automatic push_add(input int x, input int y);
        aot_pkg::t_in_req req;
        req.cmd   = aot_pkg::CMD_ADD;
        req.pos_x = clamp_pos(x);
        req.pos_y = clamp_pos(y);
        obstacle_reqs_q.push_back(req);
    endtask

    task automatic write_reg(input logic [aot_pkg::CFG_IDX_W-1:0] idx,
                             input logic [aot_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            aot_pkg::REG_FULL_LIFE:  cfg_full_life = data[aot_pkg::LIFE_W-1:0];
            aot_pkg::REG_MERGE_DIST: cfg_merge     = data[aot_pkg::DIST_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every request is taken and every result has come back
    task automatic drain();
        do @(posedge i_clk);
        while (obstacle_reqs_q.size() != 0 || i_in_valid || table_outcomes_q.size() != 0);
        repeat (END_SLACK) @(posedge i_clk);
    endtask

    task automatic set_registers(input logic [aot_pkg::CFG_DATA_W-1:0] full_life,
                                 input logic [aot_pkg::CFG_DATA_W-1:0] merge);
        drain();
        write_reg(aot_pkg::REG_FULL_LIFE, full_life);
        write_reg(aot_pkg::REG_MERGE_DIST, merge);
        n_settings++;
    endtask

    // detections cluster around a few hot spots so merges and refreshes
    // happen often; some land anywhere in the full coordinate range
    task automatic queue_random_reqs(input int n, input int tick_pct);
        int               radius;
        int               c;
        int               k;
        aot_pkg::t_in_req req;

        radius = int'(cfg_merge) + int'(cfg_merge) / 2 + 2;
        for (int h = 0; h < N_HOT; h++) begin
            if ($urandom_range(0, 3) == 0) begin
                hot_x[h] = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                hot_y[h] = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
            end else begin
                hot_x[h] = aot_pkg::POS_W'($urandom);
                hot_y[h] = aot_pkg::POS_W'($urandom);
            end
        end
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < tick_pct) begin
                // position bits still toggle on a tick
                req.cmd   = aot_pkg::CMD_TICK;
                req.pos_x = aot_pkg::POS_W'($urandom);
                req.pos_y = aot_pkg::POS_W'($urandom);
                obstacle_reqs_q.push_back(req);
            end else if (k < 88) begin
                c = $urandom_range(0, N_HOT - 1);
                push_add(int'(hot_x[c]) + $urandom_range(0, 2 * radius) - radius,
                         int'(hot_y[c]) + $urandom_range(0, 2 * radius) - radius);
            end else begin
                req.cmd   = aot_pkg::CMD_ADD;
                req.pos_x = aot_pkg::POS_W'($urandom);
                req.pos_y = aot_pkg::POS_W'($urandom);
                obstacle_reqs_q.push_back(req);
            end
        end
    endtask

    task automatic random_phase(input logic [aot_pkg::CFG_DATA_W-1:0] full_life,
                                input logic [aot_pkg::CFG_DATA_W-1:0] merge,
                                input int n, input int tick_pct,
                                input logic gaps, input logic stalls,
                                input logic pressure);
        set_registers(full_life, merge);
        @(posedge i_clk);
        send_gaps_on   <= gaps;
        recv_stalls_on <= stalls;
        if (pressure) begin
            hold_go <= 1'b1;
        end
        queue_random_reqs(n, tick_pct);
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: placement, keep at full life, refresh after aging,
        // merge radius boundary, coordinate extremes, all slots full
        n_settings++;
        push_add(0, 0);
        push_add(100, 100);
        push_tick();
        push_add(10, 10);
        push_add(160, 10);
        push_add(32767, 32767);
        push_add(-32768, -32768);
        push_add(32767, -32768);
        push_add(-32768, 32767);
        push_tick();
        push_tick();
        push_add(-32768, -32767);

        // spare indexes ignored, full life write keeps its low byte only,
        // widest radius; lives above full life match but are never oldest
        drain();
        write_reg(REG_SPARE_A, 12'hFFF);
        write_reg(REG_SPARE_B, 12'hABC);
        set_registers(12'hF05, 12'd4095);
        push_add(-30000, 32000);
        push_add(20000, 0);
        push_tick();
        push_add(20010, 5);

        // full life zero and zero radius: every add places into slot 0 dead
        set_registers(12'd0, 12'd0);
        push_add(1, 1);
        push_add(1, 1);
        push_tick();
        push_add(-5, 7);

        // radius one: same point merges, one step off in x does not
        set_registers(12'd255, 12'd1);
        push_add(7, 7);
        push_add(7, 7);
        push_tick();
        push_add(7, 7);
        push_add(8, 7);

        // random phases over several settings, extremes included
        random_phase(12'd100, 12'd150, 200, 30, 1'b1, 1'b1, 1'b0);
        random_phase(12'd255, 12'd4095, 200, 25, 1'b1, 1'b1, 1'b0);
        random_phase(12'd1, 12'd0, 150, 40, 1'b1, 1'b1, 1'b0);
        random_phase(12'd3, 12'd300, 250, 35, 1'b0, 1'b1, 1'b1);
        random_phase(12'd0, 12'd2000, 100, 30, 1'b1, 1'b1, 1'b0);
        random_phase(aot_pkg::CFG_DATA_W'($urandom), aot_pkg::CFG_DATA_W'($urandom),
                     200, 30, 1'b1, 1'b1, 1'b0);
        random_phase(12'd20, 12'd60, 250, 20, 1'b0, 1'b0, 1'b0);
        random_phase(12'd255, 12'd1, 150, 15, 1'b1, 1'b1, 1'b0);
        random_phase(12'd8, 12'd800, 100, 45, 1'b1, 1'b1, 1'b0);

        drain();
        $display("covered %0d ticks and %0d adds over %0d register settings",
                 n_ticks, n_adds, n_settings);
        $display("results seen: %0d aged, %0d kept, %0d refreshed, %0d placed",
                 act_seen[aot_pkg::ACT_AGED], act_seen[aot_pkg::ACT_MATCH_KEEP],
                 act_seen[aot_pkg::ACT_MATCH_REFRESH], act_seen[aot_pkg::ACT_PLACED]);
        if (mismatch_cnt == 0 && table_outcomes_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
